@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the frame mirror filter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked on every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  `ASSERT_PROP(label, clk, rst_n, !(expr), msg)

`endif

@@ design/fmf_pkg.sv @@
// ----------------------------------------------------------------------------
// Frame mirror filter package
// Register map, mirror mode codes, field widths and the configuration struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fmf_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int PIXEL_W    = 32;
  localparam int MODE_W     = 4;
  localparam int MASK_W     = 24;
  localparam int SIZE_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Depth of the request queue between front and back, and of the output skid.
  localparam int QUEUE_DEPTH = 4;
  localparam int SKID_DEPTH  = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_XOR_MASK     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd3;

  // Mirror modes; codes above MODE_TOP_RIGHT behave as MODE_NONE.
  localparam logic [MODE_W-1:0] MODE_NONE         = 4'd0;
  localparam logic [MODE_W-1:0] MODE_LEFT         = 4'd1;
  localparam logic [MODE_W-1:0] MODE_RIGHT        = 4'd2;
  localparam logic [MODE_W-1:0] MODE_BOTTOM       = 4'd3;
  localparam logic [MODE_W-1:0] MODE_BOTTOM_LEFT  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_BOTTOM_RIGHT = 4'd5;
  localparam logic [MODE_W-1:0] MODE_TOP          = 4'd6;
  localparam logic [MODE_W-1:0] MODE_TOP_LEFT     = 4'd7;
  localparam logic [MODE_W-1:0] MODE_TOP_RIGHT    = 4'd8;

  localparam logic [MODE_W-1:0] RESET_MODE   = MODE_NONE;
  localparam logic [MASK_W-1:0] RESET_MASK   = '0;
  localparam logic [SIZE_W-1:0] RESET_WIDTH  = 9'd256;
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = 9'd256;

  typedef struct packed {
    logic [MODE_W-1:0] mirror_mode;
    logic [MASK_W-1:0] xor_mask;
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;
  } cfg_t;

endpackage

@@ design/frame_mirror_filter_top.sv @@
// ----------------------------------------------------------------------------
// Frame mirror filter
// Ping-pong frame delay that returns the previous frame mirrored and masked.
// ----------------------------------------------------------------------------
// After reset the block clears both banks of the frame store, one entry per
// cycle, and holds in_stall_o high until all 2 * 2**clog2(MaxWidth) *
// 2**clog2(MaxHeight) entries (131072 at the default 256 by 256) are clear;
// configuration writes are taken during that time. It then takes one pixel
// per clock and gives one result pixel per clock while out_stall_i is low
// and the request queue has room: the single store port pair (one write and
// one read per cycle) sets that rate. Results are pixels of the previous
// frame, so the first frame returns zero XOR the mask.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module frame_mirror_filter_top import fmf_pkg::*; #(
  parameter int MaxWidth  = MAX_WIDTH_DEF,
  parameter int MaxHeight = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIXEL_W-1:0]    pixel_in_i,
  input  logic                  frame_start_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIXEL_W-1:0]    pixel_out_o,
  output logic                  frame_end_o
);

  localparam int AW = 1 + $clog2(MaxWidth) + $clog2(MaxHeight);
  localparam int QW = 1 + PIXEL_W + 2 * AW;

  cfg_t          cfg_q;
  logic          clearing;
  logic          q_push, q_pop, q_full, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mirror_mode  <= RESET_MODE;
      cfg_q.xor_mask     <= RESET_MASK;
      cfg_q.frame_width  <= RESET_WIDTH;
      cfg_q.frame_height <= RESET_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIRROR_MODE:  cfg_q.mirror_mode  <= cfg_data_i[MODE_W-1:0];
        REG_XOR_MASK:     cfg_q.xor_mask     <= cfg_data_i[MASK_W-1:0];
        REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data_i[SIZE_W-1:0];
        REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fmf_front #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .clearing_i    (clearing),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_in_i    (pixel_in_i),
    .frame_start_i (frame_start_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  fmf_fifo #(
    .Width (QW),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty),
    .full_o  (q_full),
    .count_o ()
  );

  fmf_back #(
    .AddrW (AW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .clearing_o  (clearing),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o),
    .frame_end_o (frame_end_o)
  );

  `ASSERT_NEVER(a_queue_overflow, clk_i, rst_ni, q_push && q_full, "request queue overflow")
  `ASSERT_NEVER(a_queue_underflow, clk_i, rst_ni, q_pop && q_empty, "request queue underflow")
  `ASSERT_PROP(a_clear_quiet, clk_i, rst_ni,
               clearing |-> !(in_valid_i && !in_stall_o) && !out_valid_o && !q_pop,
               "activity during store clear")

endmodule

@@ design/fmf_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmf_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/fmf_fifo.sv @@
// ----------------------------------------------------------------------------
// Small FIFO
// Register-based queue with simultaneous push and pop and a fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmf_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [Width-1:0]           rdata_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int PW = $clog2(Depth);
  localparam int NW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + NW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == NW'(Depth));
  assign count_o = cnt_q;

endmodule

@@ design/fmf_front.sv @@
// ----------------------------------------------------------------------------
// Frame mirror filter front end
// Tracks the raster position and bank, folds it by the mirror mode and queues
// one store request (write address, read address, pixel, frame end) per pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmf_front import fmf_pkg::*; #(
  parameter int MaxWidth  = MAX_WIDTH_DEF,
  parameter int MaxHeight = MAX_HEIGHT_DEF,
  localparam int AW = 1 + $clog2(MaxWidth) + $clog2(MaxHeight),
  localparam int QW = 1 + PIXEL_W + 2 * AW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               clearing_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [PIXEL_W-1:0] pixel_in_i,
  input  logic               frame_start_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output logic [QW-1:0]      q_data_o
);

  localparam int CW  = $clog2(MaxWidth);
  localparam int RW  = $clog2(MaxHeight);
  localparam int WW  = CW + 1;
  localparam int HW  = RW + 1;
  localparam int EWW = (WW > SIZE_W) ? WW : SIZE_W;
  localparam int EHW = (HW > SIZE_W) ? HW : SIZE_W;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          bank_q, bank;

  logic [EWW-1:0] fw_e, w_e;
  logic [EHW-1:0] fh_e, h_e;
  logic [WW-1:0]  w, wm1, col0, col1, dbl_c, sx;
  logic [HW-1:0]  h, hm1, row0, row1, row2, dbl_r, sy, row_inc;
  logic           col_wrap, eol;
  logic           left, right, top, bottom;
  logic           frame_end;
  logic           in_fire;
  logic [AW-1:0]  wr_addr, rd_addr;

  // Sizes outside the legal range act as the nearest limit.
  assign fw_e = EWW'(cfg_i.frame_width);
  assign fh_e = EHW'(cfg_i.frame_height);
  assign w_e  = (fw_e < EWW'(2)) ? EWW'(2) :
                (fw_e > EWW'(MaxWidth)) ? EWW'(MaxWidth) : fw_e;
  assign h_e  = (fh_e < EHW'(2)) ? EHW'(2) :
                (fh_e > EHW'(MaxHeight)) ? EHW'(MaxHeight) : fh_e;
  assign w    = w_e[WW-1:0];
  assign h    = h_e[HW-1:0];
  assign wm1  = w - WW'(1);
  assign hm1  = h - HW'(1);

  assign left   = cfg_i.mirror_mode inside {MODE_LEFT, MODE_BOTTOM_LEFT, MODE_TOP_LEFT};
  assign right  = cfg_i.mirror_mode inside {MODE_RIGHT, MODE_BOTTOM_RIGHT, MODE_TOP_RIGHT};
  assign top    = cfg_i.mirror_mode inside {MODE_TOP, MODE_TOP_LEFT, MODE_TOP_RIGHT};
  assign bottom = cfg_i.mirror_mode inside {MODE_BOTTOM, MODE_BOTTOM_LEFT,
                                            MODE_BOTTOM_RIGHT};

  // A frame start swaps banks and restarts at the origin; a position left
  // beyond a shrunk frame is wrapped first.
  assign bank     = bank_q ^ frame_start_i;
  assign col0     = frame_start_i ? '0 : {1'b0, col_q};
  assign row0     = frame_start_i ? '0 : {1'b0, row_q};
  assign col_wrap = (col0 >= w);
  assign col1     = col_wrap ? '0 : col0;
  assign row1     = col_wrap ? row0 + HW'(1) : row0;
  assign row2     = (row1 >= h) ? '0 : row1;

  // Mirror fold: a position in the replaced half reads its partner, and an odd
  // middle line reads itself.
  assign dbl_c = {col1[CW-1:0], 1'b0};
  assign dbl_r = {row2[RW-1:0], 1'b0};
  assign sx = ((left && dbl_c > wm1) || (right && dbl_c < wm1)) ? wm1 - col1 : col1;
  assign sy = ((top && dbl_r > hm1) || (bottom && dbl_r < hm1)) ? hm1 - row2 : row2;

  assign eol       = (col1 == wm1);
  assign frame_end = eol && (row2 == hm1);

  assign wr_addr = {bank, row2[RW-1:0], col1[CW-1:0]};
  assign rd_addr = {~bank, sy[RW-1:0], sx[CW-1:0]};

  assign in_stall_o = clearing_i || q_full_i;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign q_push_o   = in_fire;
  assign q_data_o   = {frame_end, pixel_in_i, wr_addr, rd_addr};

  assign row_inc = row2 + HW'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_fire) begin
      if (eol) begin
        col_d = '0;
        row_d = (row_inc == h) ? '0 : row_inc[RW-1:0];
      end else begin
        col_d = col1[CW-1:0] + CW'(1);
        row_d = row2[RW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      bank_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (in_fire) begin
        bank_q <= bank;
      end
    end
  end

endmodule

@@ design/fmf_back.sv @@
// ----------------------------------------------------------------------------
// Frame mirror filter back end
// Clears the frame store after reset, then carries out one queued request per
// cycle while the skid queue has room: write the new pixel, read the mirrored
// one, apply the mask and hand the result to a two-entry output skid queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmf_back import fmf_pkg::*; #(
  parameter int AddrW = 17,
  localparam int QW = 1 + PIXEL_W + 2 * AddrW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  output logic               clearing_o,
  input  logic               q_empty_i,
  input  logic [QW-1:0]      q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PIXEL_W-1:0] pixel_out_o,
  output logic               frame_end_o
);

  localparam int SW = $clog2(SKID_DEPTH + 1);
  localparam int OW = SW + 1;

  logic [AddrW-1:0]   clr_addr_q;
  logic               clr_q;
  logic               rd_vld_q;
  logic               fe_q;

  logic [AddrW-1:0]   rd_addr, wr_addr, ram_waddr;
  logic [PIXEL_W-1:0] pixel, ram_wdata, ram_rdata, masked;
  logic               req_fe;
  logic               ram_we;
  logic               out_fire;
  logic [SW-1:0]      skid_cnt;
  logic               skid_empty;
  logic [OW-1:0]      occ;
  logic [PIXEL_W:0]   skid_rdata;

  assign rd_addr = q_data_i[AddrW-1:0];
  assign wr_addr = q_data_i[2*AddrW-1:AddrW];
  assign pixel   = q_data_i[2*AddrW+PIXEL_W-1:2*AddrW];
  assign req_fe  = q_data_i[QW-1];

  // A request is taken only if the read in flight and the skid queue leave a
  // place for its result.
  assign out_fire = out_valid_o && !out_stall_i;
  assign occ      = OW'(skid_cnt) + OW'(rd_vld_q);
  assign q_pop_o  = !clr_q && !q_empty_i && (occ <= OW'(1) + OW'(out_fire));

  assign ram_we    = clr_q || q_pop_o;
  assign ram_waddr = clr_q ? clr_addr_q : wr_addr;
  assign ram_wdata = clr_q ? '0 : pixel;

  fmf_ram #(
    .Width (PIXEL_W),
    .Depth (2 ** AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (q_pop_o),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign masked = ram_rdata ^ {{(PIXEL_W - MASK_W){1'b0}}, cfg_i.xor_mask};

  fmf_fifo #(
    .Width (PIXEL_W + 1),
    .Depth (SKID_DEPTH)
  ) u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rd_vld_q),
    .wdata_i ({fe_q, masked}),
    .pop_i   (out_fire),
    .rdata_o (skid_rdata),
    .empty_o (skid_empty),
    .full_o  (),
    .count_o (skid_cnt)
  );

  assign out_valid_o = !skid_empty;
  assign pixel_out_o = skid_rdata[PIXEL_W-1:0];
  assign frame_end_o = skid_rdata[PIXEL_W];
  assign clearing_o  = clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      rd_vld_q <= q_pop_o;
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
        if (&clr_addr_q) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      fe_q <= req_fe;
    end
  end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// Frame mirror filter testbench
// Streams pixel frames of many sizes and mirror modes into the block, works
// out each mirrored, masked pixel of the previous frame in a local copy of the
// two-bank frame store, and compares every result request with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import fmf_pkg::*;

  localparam int BANK_WORDS = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int ITEM_TARGET = 1490;
  localparam int QUIET_FROM = ITEM_TARGET - 200;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [MODE_W-1:0] MODE_FIRST_UNUSED = MODE_TOP_RIGHT + 4'd1;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               frame_end;
  } mirror_pixel_t;

  class mirror_scoreboard;
    bit [PIXEL_W-1:0] store [2*BANK_WORDS];
    bit               write_bank;
    int unsigned      column;
    int unsigned      row;
    logic [MODE_W-1:0] mode;
    logic [MASK_W-1:0] mask;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    mirror_pixel_t    expected_pixels[$];
    int unsigned      errors;

    function new();
      write_bank = 1'b0;
      column = 0;
      row = 0;
      mode = RESET_MODE;
      mask = RESET_MASK;
      width_reg = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      errors = 0;
    endfunction

    // Register values below 2 act as 2 and those above the maximum act as it.
    function int unsigned size_in_use(logic [SIZE_W-1:0] raw, int unsigned max_size);
      if (raw < 2) return 2;
      if (raw > max_size) return max_size;
      return raw;
    endfunction

    // take_low replaces the upper half with the lower one, take_high the reverse.
    function int unsigned fold(int unsigned p, int unsigned n, bit take_low,
                               bit take_high);
      if (take_low && 2 * p > n - 1) return n - 1 - p;
      if (take_high && 2 * p < n - 1) return n - 1 - p;
      return p;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MIRROR_MODE:  mode = data[MODE_W-1:0];
        REG_XOR_MASK:     mask = data[MASK_W-1:0];
        REG_FRAME_WIDTH:  width_reg = data[SIZE_W-1:0];
        REG_FRAME_HEIGHT: height_reg = data[SIZE_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [PIXEL_W-1:0] pix, logic frame_start);
      int unsigned w, h, sx, sy;
      bit left, right, top, bottom;
      mirror_pixel_t res;
      w = size_in_use(width_reg, MAX_WIDTH_DEF);
      h = size_in_use(height_reg, MAX_HEIGHT_DEF);
      left = 1'b0;
      right = 1'b0;
      top = 1'b0;
      bottom = 1'b0;
      if (frame_start) begin
        write_bank = !write_bank;
        column = 0;
        row = 0;
      end
      // The size may have shrunk under the current position.
      if (column >= w) begin
        column = 0;
        row++;
      end
      if (row >= h) row = 0;
      case (mode)
        MODE_LEFT:         left = 1'b1;
        MODE_RIGHT:        right = 1'b1;
        MODE_BOTTOM:       bottom = 1'b1;
        MODE_BOTTOM_LEFT:  begin bottom = 1'b1; left = 1'b1; end
        MODE_BOTTOM_RIGHT: begin bottom = 1'b1; right = 1'b1; end
        MODE_TOP:          top = 1'b1;
        MODE_TOP_LEFT:     begin top = 1'b1; left = 1'b1; end
        MODE_TOP_RIGHT:    begin top = 1'b1; right = 1'b1; end
        default: ;
      endcase
      sx = fold(column, w, left, right);
      sy = fold(row, h, top, bottom);
      res.pixel = store[(!write_bank) * BANK_WORDS + sy * MAX_WIDTH_DEF + sx]
                  ^ {{(PIXEL_W-MASK_W){1'b0}}, mask};
      res.frame_end = (column == w - 1) && (row == h - 1);
      store[write_bank * BANK_WORDS + row * MAX_WIDTH_DEF + column] = pix;
      expected_pixels.push_back(res);
      column++;
      if (column >= w) begin
        column = 0;
        row++;
        if (row >= h) row = 0;
      end
    endfunction

    function void check_pixel(logic [PIXEL_W-1:0] pix, logic frame_end);
      mirror_pixel_t exp_px;
      if (expected_pixels.size() == 0) begin
        $error("pixel_out: no request expected, actual %h", pix);
        errors++;
        return;
      end
      exp_px = expected_pixels.pop_front();
      if (pix !== exp_px.pixel) begin
        $error("pixel_out: expected %h, actual %h", exp_px.pixel, pix);
        errors++;
      end
      if (frame_end !== exp_px.frame_end) begin
        $error("frame_end: expected %b, actual %b", exp_px.frame_end, frame_end);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [PIXEL_W-1:0]    pixel_in_i;
  logic                  frame_start_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [PIXEL_W-1:0]    pixel_out_o;
  logic                  frame_end_o;

  mirror_scoreboard sb = new();
  int unsigned pixels_sent = 0;
  int unsigned cycle_count = 0;
  bit          long_hold_req = 1'b0;
  logic        quiet;

  assign quiet = (pixels_sent >= QUIET_FROM);

  frame_mirror_filter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_in_i    (pixel_in_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_out_o   (pixel_out_o),
    .frame_end_o   (frame_end_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [PIXEL_W-1:0] random_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Unused upper data bits carry random values; the block must ignore them.
  task automatic load_config(input logic [MODE_W-1:0] mode, input logic [MASK_W-1:0] mask,
                             input logic [SIZE_W-1:0] w_raw,
                             input logic [SIZE_W-1:0] h_raw);
    logic [CFG_DATA_W-1:0] noise;
    noise = $urandom;
    write_reg(REG_MIRROR_MODE, {noise[CFG_DATA_W-1:MODE_W], mode});
    write_reg(REG_XOR_MASK, mask);
    write_reg(REG_FRAME_WIDTH, {noise[CFG_DATA_W-1:SIZE_W], w_raw});
    write_reg(REG_FRAME_HEIGHT, {noise[CFG_DATA_W-1:SIZE_W], h_raw});
    cfg_we_i <= 1'b0;
  endtask

  task automatic offer_pixel(input logic [PIXEL_W-1:0] pix, input logic frame_start);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= pix;
    frame_start_i <= frame_start;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pixel(pix, frame_start);
    pixels_sent++;
  endtask

  task automatic send_frame(input int unsigned len, input bit with_start);
    for (int unsigned i = 0; i < len; i++)
      offer_pixel(random_pixel(), with_start && (i == 0));
  endtask

  // Holds the sender off until every outstanding request has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check_pixel(pixel_out_o, frame_end_o);
      if (stall_left > 1) begin
        stall_left--;
      end else if (stall_left == 1) begin
        stall_left = 0;
        out_stall_i <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 5);
        out_stall_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned phase, w_eff, h_eff, len;
    logic [SIZE_W-1:0] w_raw, h_raw;
    logic [MODE_W-1:0] mode;
    logic [MASK_W-1:0] mask;
    bit with_start;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_MIRROR_MODE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    pixel_in_i = '0;
    frame_start_i = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: the first frame reads the cleared store.
    offer_pixel('1, 1'b1);
    offer_pixel('0, 1'b0);
    offer_pixel(random_pixel(), 1'b0);
    wait_idle();

    // Unused mode, full mask and sizes below the minimum. The first pixel has
    // no frame start, so the shrunk width moves it to the next row; the last
    // two run past the end of the frame and wrap within the same bank.
    load_config(MODE_FIRST_UNUSED, '1, 9'd0, 9'd1);
    offer_pixel(random_pixel(), 1'b0);
    send_frame(4, 1'b1);
    send_frame(4, 1'b1);
    send_frame(2, 1'b0);
    wait_idle();

    // Odd size: the middle row and column read themselves.
    load_config(MODE_TOP_LEFT, '0, 9'd3, 9'd3);
    send_frame(9, 1'b1);
    wait_idle();

    phase = 0;
    while (pixels_sent < ITEM_TARGET) begin
      if (phase == 0) begin
        w_raw = 9'd511;
        h_raw = 9'd1;
      end else if (phase == 1) begin
        w_raw = 9'd0;
        h_raw = 9'd256;
      end else begin
        w_raw = $urandom_range(0, 12);
        h_raw = $urandom_range(0, 12);
      end
      if ($urandom_range(0, 3) == 0) mode = $urandom_range(0, 15);
      else mode = $urandom_range(MODE_LEFT, MODE_TOP_RIGHT);
      case ($urandom_range(0, 3))
        0: mask = '0;
        1: mask = '1;
        default: mask = $urandom;
      endcase
      load_config(mode, mask, w_raw, h_raw);
      w_eff = sb.size_in_use(w_raw, MAX_WIDTH_DEF);
      h_eff = sb.size_in_use(h_raw, MAX_HEIGHT_DEF);
      if (phase == 0) long_hold_req = 1'b1;
      if (phase < 2) begin
        send_frame(w_eff * h_eff, 1'b1);
        send_frame(16, 1'b1);
      end else begin
        repeat ($urandom_range(2, 4)) begin
          len = w_eff * h_eff;
          with_start = 1'b1;
          case ($urandom_range(0, 7))
            0: len = $urandom_range(1, len);
            1: len = len + $urandom_range(1, len);
            2: with_start = 1'b0;
            default: ;
          endcase
          send_frame(len, with_start);
        end
      end
      wait_idle();
      phase++;
    end

    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
